### src/rlrd_pkg.sv
// Shared constants and types for the run-length decoder.
package rlrd_pkg;

  localparam int OUT_LANES  = 4;
  localparam int SIZE_WIDTH = 32;
  localparam int CNT_W      = 8;
  localparam int LANE_W     = $clog2(OUT_LANES + 1);
  localparam int Q_DEPTH    = 4;
  localparam int Q_AW       = $clog2(Q_DEPTH);

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TRUNCATED = 2'd1;
  localparam logic [1:0] ST_OVERRUN   = 2'd2;
  localparam logic [1:0] ST_MISMATCH  = 2'd3;

  localparam logic [6:0] LOW7 = 7'h7F;

  // One decode job for the back end: count copies of value, then the
  // status if the job closes a stream. A count of zero carries status only.
  typedef struct packed {
    logic [7:0]       value;
    logic [CNT_W-1:0] count;
    logic             eos;
    logic [1:0]       status;
  } rlrd_cmd_t;

endpackage

### src/rle_run_decoder.sv
// Top level of the run-length decoder: front end, job queue and back end.
//
// Compressed bytes enter through a queue-like port: a byte transfers when
// push is high and full is low; end_of_stream marks the last byte of a stream.
// Decoded bytes leave through a second queue-like port: the oldest beat sits
// on out_bytes, byte_count and the flags while empty is low, and transfers
// when pop is high. Up to four bytes leave per beat, the first in bits 7:0.
// The expected size is written through cfg_write and cfg_data while idle.
// A byte that produces output passes through the job queue, the back end's
// current job and the output beat register before its first beat shows. The
// front end takes one byte per cycle while the four-entry job queue has room;
// the back end issues one beat per cycle while the receiver keeps up, so a
// literal byte takes one beat and a repeat run of n bytes takes ceil(n / 4)
// beats of the output port. A long repeat run therefore fills the queue and holds full.
// When the receiver stalls, the current beat holds and the back end, then the
// queue, then the input port back up in turn. Reset empties both ports, clears
// the stream state and sets the expected size to zero.
module rle_run_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [31:0] cfg_data,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_byte,
  input  logic        end_of_stream,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_bytes,
  output logic [2:0]  byte_count,
  output logic        last_of_run,
  output logic        stream_done,
  output logic [1:0]  status
);
  import rlrd_pkg::*;

  logic      accept;
  logic      job_push;
  rlrd_cmd_t new_job;
  logic      has_job;
  logic      job_pop;
  rlrd_cmd_t head_job;

  assign accept = push && !full;

  rlrd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_data      (cfg_data),
    .accept        (accept),
    .in_byte       (in_byte),
    .end_of_stream (end_of_stream),
    .job_push      (job_push),
    .job           (new_job)
  );

  rlrd_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (job_push),
    .wr_job  (new_job),
    .full    (full),
    .rd_en   (job_pop),
    .has_job (has_job),
    .rd_job  (head_job)
  );

  rlrd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .has_job     (has_job),
    .job         (head_job),
    .job_pop     (job_pop),
    .empty       (empty),
    .pop         (pop),
    .out_bytes   (out_bytes),
    .byte_count  (byte_count),
    .last_of_run (last_of_run),
    .stream_done (stream_done),
    .status      (status)
  );

endmodule

### src/rlrd_front.sv
// Front end: parses command bytes, checks sizes and queues decode jobs.
module rlrd_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [31:0]        cfg_data,
  input  logic               accept,
  input  logic [7:0]         in_byte,
  input  logic               end_of_stream,
  output logic               job_push,
  output rlrd_pkg::rlrd_cmd_t job
);
  import rlrd_pkg::*;

  typedef enum logic [1:0] {
    PH_CMD = 2'd0,
    PH_REP = 2'd1,
    PH_LIT = 2'd2
  } phase_t;

  logic [31:0]           expected_size;
  phase_t                phase, phase_next;
  logic [6:0]            literal_left, literal_left_next;
  logic [SIZE_WIDTH-1:0] decoded_count, decoded_count_next;
  logic [1:0]            error_code, error_code_next;

  logic [SIZE_WIDTH-1:0] limit;
  logic [CNT_W-1:0]      addend;
  logic [SIZE_WIDTH:0]   sum;
  logic                  overrun;
  logic                  data_push;
  logic [CNT_W-1:0]      data_count;
  logic [1:0]            final_status;

  assign limit   = expected_size[SIZE_WIDTH-1:0];
  assign sum     = {1'b0, decoded_count} + (SIZE_WIDTH + 1)'(addend);
  assign overrun = sum > {1'b0, limit};

  always_comb begin
    case (phase)
      PH_REP:  addend = CNT_W'(literal_left) + CNT_W'(2);
      PH_LIT:  addend = CNT_W'(1);
      default: addend = CNT_W'(in_byte[6:0]) + CNT_W'(1);
    endcase
  end

  always_comb begin
    phase_next         = phase;
    literal_left_next  = literal_left;
    decoded_count_next = decoded_count;
    error_code_next    = error_code;
    data_push          = 1'b0;
    data_count         = '0;
    if (error_code == ST_OK) begin
      case (phase)
        PH_REP: begin
          if (overrun) begin
            error_code_next = ST_OVERRUN;
          end else begin
            data_push          = 1'b1;
            data_count         = addend;
            decoded_count_next = sum[SIZE_WIDTH-1:0];
          end
          literal_left_next = '0;
          phase_next        = PH_CMD;
        end
        PH_LIT: begin
          data_push          = 1'b1;
          data_count         = CNT_W'(1);
          decoded_count_next = sum[SIZE_WIDTH-1:0];
          if (literal_left == '0) begin
            phase_next = PH_CMD;
          end else begin
            literal_left_next = literal_left - 7'd1;
            if (end_of_stream) error_code_next = ST_TRUNCATED;
          end
        end
        default: begin
          if (in_byte[7]) begin
            literal_left_next = in_byte[6:0] & LOW7;
            phase_next        = PH_REP;
            if (end_of_stream) error_code_next = ST_TRUNCATED;
          end else if (overrun) begin
            error_code_next = ST_OVERRUN;
          end else begin
            literal_left_next = in_byte[6:0];
            phase_next        = PH_LIT;
            if (end_of_stream) error_code_next = ST_TRUNCATED;
          end
        end
      endcase
    end
  end

  always_comb begin
    if (error_code_next != ST_OK) begin
      final_status = error_code_next;
    end else if (decoded_count_next != limit) begin
      final_status = ST_MISMATCH;
    end else begin
      final_status = ST_OK;
    end
  end

  // Every accepted byte that yields data, or ends a stream, becomes one job.
  assign job_push   = accept && (data_push || end_of_stream);
  assign job.value  = in_byte;
  assign job.count  = data_count;
  assign job.eos    = end_of_stream;
  assign job.status = end_of_stream ? final_status : ST_OK;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_size <= '0;
      phase         <= PH_CMD;
      literal_left  <= '0;
      decoded_count <= '0;
      error_code    <= ST_OK;
    end else begin
      if (cfg_write) expected_size <= cfg_data;
      if (accept) begin
        if (end_of_stream) begin
          phase         <= PH_CMD;
          literal_left  <= '0;
          decoded_count <= '0;
          error_code    <= ST_OK;
        end else begin
          phase         <= phase_next;
          literal_left  <= literal_left_next;
          decoded_count <= decoded_count_next;
          error_code    <= error_code_next;
        end
      end
    end
  end

endmodule

### src/rlrd_queue.sv
// Short job queue between the parsing front end and the expanding back end.
module rlrd_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                wr_en,
  input  rlrd_pkg::rlrd_cmd_t wr_job,
  output logic                full,
  input  logic                rd_en,
  output logic                has_job,
  output rlrd_pkg::rlrd_cmd_t rd_job
);
  import rlrd_pkg::*;

  rlrd_cmd_t     slots [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr;
  logic [Q_AW-1:0] rd_ptr;
  logic [Q_AW:0]   fill;

  assign full    = fill == (Q_AW + 1)'(Q_DEPTH);
  assign has_job = fill != '0;
  assign rd_job  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) slots[wr_ptr] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr_en) wr_ptr <= wr_ptr + Q_AW'(1);
      if (rd_en) rd_ptr <= rd_ptr + Q_AW'(1);
      case ({wr_en, rd_en})
        2'b10:   fill <= fill + (Q_AW + 1)'(1);
        2'b01:   fill <= fill - (Q_AW + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

### src/rlrd_back.sv
// Back end: expands queued jobs into packed output beats.
module rlrd_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                has_job,
  input  rlrd_pkg::rlrd_cmd_t job,
  output logic                job_pop,
  output logic                empty,
  input  logic                pop,
  output logic [31:0]         out_bytes,
  output logic [2:0]          byte_count,
  output logic                last_of_run,
  output logic                stream_done,
  output logic [1:0]          status
);
  import rlrd_pkg::*;

  rlrd_cmd_t        cur;
  logic             cur_valid;
  logic [CNT_W-1:0] remaining;
  logic             out_valid;

  logic              emit;
  logic              beat_last;
  logic [LANE_W-1:0] beat_count;
  logic [31:0]       beat_bytes;

  assign beat_last  = remaining <= CNT_W'(OUT_LANES);
  assign beat_count = beat_last ? LANE_W'(remaining) : LANE_W'(OUT_LANES);
  assign emit       = cur_valid && (!out_valid || pop);
  assign job_pop    = has_job && (!cur_valid || (emit && beat_last));
  assign empty      = !out_valid;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      beat_bytes[8*i +: 8] = (i < int'(beat_count)) ? cur.value : 8'h00;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (job_pop) begin
        cur_valid <= 1'b1;
        cur       <= job;
        remaining <= job.count;
      end else if (emit) begin
        if (beat_last) cur_valid <= 1'b0;
        remaining <= remaining - CNT_W'(beat_count);
      end
      if (emit) begin
        out_valid   <= 1'b1;
        out_bytes   <= beat_bytes;
        byte_count  <= 3'(beat_count);
        last_of_run <= beat_last;
        stream_done <= beat_last && cur.eos;
        status      <= (beat_last && cur.eos) ? cur.status : ST_OK;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
